[rtl/core/kalman_angle_bias_filter_defines.svh]
// Assertion macros shared by the angle/bias filter RTL.
// Needs nothing else; expands to nothing when SYNTHESIS is defined.
`ifndef KALMAN_ANGLE_BIAS_FILTER_DEFINES_SVH
`define KALMAN_ANGLE_BIAS_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
`define KAB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("kab: same-cycle check failed");
`define KAB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("kab: next-cycle check failed");
`else
`define KAB_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define KAB_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/core/kab_pkg.sv]
// Types, constants and helpers for the angle/bias filter.
// No dependencies.
`default_nettype none
package kab_pkg;

    localparam logic [30:0] RST_ANGLE_NOISE = 31'd16777;
    localparam logic [30:0] RST_BIAS_NOISE  = 31'd50332;
    localparam logic [30:0] RST_MEAS_NOISE  = 31'd503316;

    localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
    localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_ANG,
        OP_P11,
        OP_P00,
        OP_QB,
        OP_K0Y,
        OP_K1Y,
        OP_K1P00,
        OP_K1P01,
        OP_K0P00,
        OP_K0P01
    } t_mop;

    // a is signed 35 bits, b signed 32 bits
    typedef struct packed {
        logic [34:0] a;
        logic [31:0] b;
        logic        sh24;
    } t_mul_req;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [33:0] den;
    } t_div_req;

    function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
        logic signed [31:0] res;
        if (v > 53'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -53'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[rtl/core/kab_mul.sv]
// Shared two-stage multiplier with round-half-up shift by 16 or 24.
// Uses kab_pkg.
`default_nettype none
module kab_mul
    import kab_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_mul_req           i_req,
    output logic signed [50:0]      o_res
);

    logic signed [66:0] r_prod;
    logic               r_sh24;
    logic signed [66:0] w_sum;

    always_ff @(posedge i_clk) begin
        r_prod <= 67'($signed(i_req.a)) * 67'($signed(i_req.b));
        r_sh24 <= i_req.sh24;
    end

    assign w_sum = r_prod + (r_sh24 ? 67'sd8388608 : 67'sd32768);

    always_ff @(posedge i_clk) begin
        o_res <= r_sh24 ? 51'(w_sum >>> 24) : 51'(w_sum >>> 16);
    end

endmodule
`default_nettype wire

[rtl/core/kab_div.sv]
// Radix-2 restoring divider for the gains: (num * 2^24) / den, toward zero,
// saturated to 32 bits, zero for a zero divisor. Uses kab_pkg.
`default_nettype none
module kab_div
    import kab_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_div_req    i_req,
    output logic             o_done,
    output logic signed [31:0] o_quot
);

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [32:0] r_rem;
    logic [31:0] r_qd;
    logic [32:0] r_d;
    logic        r_neg;

    logic [31:0] w_num_mag;
    logic [33:0] w_den_neg;
    logic [32:0] w_den_mag;
    logic        w_ov;
    logic [33:0] w_t;
    logic [33:0] w_diff;
    logic        w_ge;
    logic [32:0] w_qneg;
    logic signed [31:0] w_fin;

    assign w_num_mag = i_req.num[31] ? 32'(-i_req.num) : i_req.num;
    assign w_den_neg = -i_req.den;
    assign w_den_mag = i_req.den[33] ? w_den_neg[32:0] : i_req.den[32:0];
    // quotient would reach 2^32: saturates, and keeps the loop at 32 steps
    assign w_ov = {9'd0, w_num_mag} >= {w_den_mag, 8'd0};

    assign w_t    = {r_rem, r_qd[31]};
    assign w_diff = w_t - {1'b0, r_d};
    assign w_ge   = w_t >= {1'b0, r_d};

    assign w_qneg = -{1'b0, r_qd};
    always_comb begin
        if (r_neg) begin
            w_fin = (r_qd > 32'h80000000) ? 32'sh80000000 : w_qneg[31:0];
        end else begin
            w_fin = r_qd[31] ? 32'sh7fffffff : r_qd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_rem <= {9'd0, w_num_mag[31:8]};
                r_qd  <= {w_num_mag[7:0], 24'd0};
                r_d   <= w_den_mag;
                r_neg <= i_req.num[31] ^ i_req.den[33];
                r_cnt <= '0;
                if (i_req.den == '0) begin
                    o_quot <= '0;
                    o_done <= 1'b1;
                end else if (w_ov) begin
                    o_quot <= (i_req.num[31] ^ i_req.den[33]) ? 32'sh80000000
                                                              : 32'sh7fffffff;
                    o_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_cnt == 6'd32) begin
                    o_quot <= w_fin;
                    o_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_rem <= w_ge ? w_diff[32:0] : w_t[32:0];
                    r_qd  <= {r_qd[30:0], w_ge};
                    r_cnt <= r_cnt + 6'd1;
                end
            end
        end
    end

endmodule
`default_nettype wire

[rtl/core/kalman_angle_bias_filter.sv]
// Two-state angle/bias Kalman filter: sequencer, state and APB registers.
// Uses kab_pkg, kab_mul, kab_div and the assertion macro header.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries gyro rate, accelerometer
//   angle and elapsed time; one request is taken while the core is idle.
//   Output channel (o_out_valid / i_out_stall) returns the filtered angle and
//   gyro bias, one result per request.
//   Each request runs ten multiplies through the one shared two-stage
//   multiplier and two 32-step gain divisions, which take most of the
//   processing time. A zero or saturating divisor ends its division
//   without the 32 steps.
//   The core takes one request at a time; the next request is taken as soon
//   as the result sits in the output register, even if the receiver has not
//   yet taken it. If the receiver stalls with a result still held, the core
//   waits at its final step and holds the new result until the register
//   frees. Reset (synchronous, active low) clears estimates and covariance
//   to zero and loads the default noise settings. Noise registers sit at
//   byte addresses 0, 4 and 8; the user must write them only while the core
//   is idle, which the core itself does not enforce.
`default_nettype none
`include "kalman_angle_bias_filter_defines.svh"
module kalman_angle_bias_filter
    import kab_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [31:0] i_gyro_rate,
    input  wire logic signed [31:0] i_measured_angle,
    input  wire logic [15:0]        i_elapsed_time,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_filtered_angle,
    output logic signed [31:0]      o_rate_bias,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    t_state r_state, n_state;
    t_mop   r_op, n_op;
    logic [1:0] r_cnt, n_cnt;
    logic r_div_sel, n_div_sel;
    logic signed [31:0] r_angle, n_angle, r_bias, n_bias;
    logic signed [31:0] r_p00, n_p00, r_p01, n_p01, r_p10, n_p10, r_p11, n_p11;
    logic signed [34:0] r_inner, n_inner;
    logic signed [31:0] r_y, n_y, r_k0, n_k0, r_k1, n_k1;
    logic signed [33:0] r_s, n_s;
    logic signed [31:0] r_rate, n_rate, r_meas, n_meas;
    logic [15:0] r_dt, n_dt;
    logic r_out_valid, n_out_valid;
    logic signed [31:0] r_out_angle, n_out_angle, r_out_bias, n_out_bias;
    logic [30:0] r_qa, r_qb, r_qr;

    t_mul_req w_mul_req;
    t_div_req w_div_req;
    logic signed [50:0] w_mul_res;
    logic signed [52:0] w_r;
    logic w_div_done;
    logic signed [31:0] w_div_quot;
    logic w_accept;
    logic w_cfg_wr;

    kab_mul u_mul (
        .i_clk (i_clk),
        .i_req (w_mul_req),
        .o_res (w_mul_res)
    );

    kab_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa <= RST_ANGLE_NOISE;
            r_qb <= RST_BIAS_NOISE;
            r_qr <= RST_MEAS_NOISE;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_ANGLE_NOISE: r_qa <= pwdata[30:0];
                REG_BIAS_NOISE:  r_qb <= pwdata[30:0];
                REG_MEAS_NOISE:  r_qr <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ANGLE_NOISE: prdata = {1'b0, r_qa};
            REG_BIAS_NOISE:  prdata = {1'b0, r_qb};
            REG_MEAS_NOISE:  prdata = {1'b0, r_qr};
            default:         prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign o_in_stall       = (r_state != ST_IDLE);
    assign w_accept         = i_in_valid && !o_in_stall;
    assign o_out_valid      = r_out_valid;
    assign o_filtered_angle = r_out_angle;
    assign o_rate_bias      = r_out_bias;

    // ---------------- multiplier operands ----------------
    always_comb begin
        w_mul_req.sh24 = 1'b1;
        w_mul_req.a    = 35'(r_k0);
        w_mul_req.b    = r_y;
        case (r_op)
            OP_ANG: begin
                w_mul_req.a = 35'(r_rate);
                w_mul_req.b = {16'd0, r_dt};
                w_mul_req.sh24 = 1'b0;
            end
            OP_P11: begin
                w_mul_req.a = 35'(r_p11);
                w_mul_req.b = {16'd0, r_dt};
                w_mul_req.sh24 = 1'b0;
            end
            OP_P00: begin
                w_mul_req.a = r_inner;
                w_mul_req.b = {16'd0, r_dt};
                w_mul_req.sh24 = 1'b0;
            end
            OP_QB: begin
                w_mul_req.a = {4'd0, r_qb};
                w_mul_req.b = {16'd0, r_dt};
                w_mul_req.sh24 = 1'b0;
            end
            OP_K0Y:   w_mul_req.b = r_y;
            OP_K1Y: begin
                w_mul_req.a = 35'(r_k1);
            end
            OP_K1P00: begin
                w_mul_req.a = 35'(r_k1);
                w_mul_req.b = r_p00;
            end
            OP_K1P01: begin
                w_mul_req.a = 35'(r_k1);
                w_mul_req.b = r_p01;
            end
            OP_K0P00: w_mul_req.b = r_p00;
            OP_K0P01: w_mul_req.b = r_p01;
            default: ;
        endcase
    end

    assign w_div_req.start = (r_state == ST_DIV) && (r_cnt == 2'd0);
    assign w_div_req.num   = r_div_sel ? r_p10 : r_p00;
    assign w_div_req.den   = r_s;

    assign w_r = 53'(w_mul_res);

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        n_op = r_op;
        n_cnt = r_cnt;
        n_div_sel = r_div_sel;
        n_angle = r_angle;
        n_bias = r_bias;
        n_p00 = r_p00;
        n_p01 = r_p01;
        n_p10 = r_p10;
        n_p11 = r_p11;
        n_inner = r_inner;
        n_y = r_y;
        n_s = r_s;
        n_k0 = r_k0;
        n_k1 = r_k1;
        n_rate = r_rate;
        n_meas = r_meas;
        n_dt = r_dt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_angle = r_out_angle;
        n_out_bias = r_out_bias;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_rate  = sat32(53'(i_gyro_rate) - 53'(r_bias));
                    n_meas  = i_measured_angle;
                    n_dt    = i_elapsed_time;
                    n_op    = OP_ANG;
                    n_cnt   = 2'd0;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (r_cnt != 2'd2) begin
                    n_cnt = r_cnt + 2'd1;
                end else begin
                    n_cnt = 2'd0;
                    case (r_op)
                        OP_ANG: begin
                            n_angle = sat32(53'(r_angle) + w_r);
                            n_op = OP_P11;
                        end
                        OP_P11: begin
                            // w_r is dt*P11 here; inner term stays exact
                            n_inner = 35'(w_r - 53'(r_p01) - 53'(r_p10)
                                          + 53'($signed({22'd0, r_qa})));
                            n_p01 = sat32(53'(r_p01) - w_r);
                            n_p10 = sat32(53'(r_p10) - w_r);
                            n_op = OP_P00;
                        end
                        OP_P00: begin
                            n_p00 = sat32(53'(r_p00) + w_r);
                            n_op = OP_QB;
                        end
                        OP_QB: begin
                            n_p11 = sat32(53'(r_p11) + w_r);
                            n_state = ST_PREP;
                        end
                        OP_K0Y: begin
                            n_angle = sat32(53'(r_angle) + w_r);
                            n_op = OP_K1Y;
                        end
                        OP_K1Y: begin
                            n_bias = sat32(53'(r_bias) + w_r);
                            n_op = OP_K1P00;
                        end
                        // bias row first: it needs P00 and P01 before their update
                        OP_K1P00: begin
                            n_p10 = sat32(53'(r_p10) - w_r);
                            n_op = OP_K1P01;
                        end
                        OP_K1P01: begin
                            n_p11 = sat32(53'(r_p11) - w_r);
                            n_op = OP_K0P00;
                        end
                        OP_K0P00: begin
                            n_p00 = sat32(53'(r_p00) - w_r);
                            n_op = OP_K0P01;
                        end
                        OP_K0P01: begin
                            n_p01 = sat32(53'(r_p01) - w_r);
                            n_state = ST_DONE;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PREP: begin
                n_y = sat32(53'(r_meas) - 53'(r_angle));
                n_s = 34'(r_p00) + $signed({3'd0, r_qr});
                n_div_sel = 1'b0;
                n_cnt = 2'd0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == 2'd0) begin
                    n_cnt = 2'd1;
                end else if (w_div_done) begin
                    n_cnt = 2'd0;
                    if (!r_div_sel) begin
                        n_k0 = w_div_quot;
                        n_div_sel = 1'b1;
                    end else begin
                        n_k1 = w_div_quot;
                        n_op = OP_K0Y;
                        n_state = ST_MUL;
                    end
                end
            end
            ST_DONE: begin
                if (!(r_out_valid && i_out_stall)) begin
                    n_out_valid = 1'b1;
                    n_out_angle = r_angle;
                    n_out_bias = r_bias;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op <= OP_ANG;
            r_cnt <= '0;
            r_div_sel <= 1'b0;
            r_out_valid <= 1'b0;
            r_angle <= '0;
            r_bias <= '0;
            r_p00 <= '0;
            r_p01 <= '0;
            r_p10 <= '0;
            r_p11 <= '0;
        end else begin
            r_state <= n_state;
            r_op <= n_op;
            r_cnt <= n_cnt;
            r_div_sel <= n_div_sel;
            r_out_valid <= n_out_valid;
            r_angle <= n_angle;
            r_bias <= n_bias;
            r_p00 <= n_p00;
            r_p01 <= n_p01;
            r_p10 <= n_p10;
            r_p11 <= n_p11;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inner <= n_inner;
        r_y <= n_y;
        r_s <= n_s;
        r_k0 <= n_k0;
        r_k1 <= n_k1;
        r_rate <= n_rate;
        r_meas <= n_meas;
        r_dt <= n_dt;
        r_out_angle <= n_out_angle;
        r_out_bias <= n_out_bias;
    end

    `KAB_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, w_accept, (r_state == ST_MUL) && (r_op == OP_ANG))
    `KAB_ASSERT_IMP(a_div_in_div, i_clk, i_rst_n, w_div_req.start, r_state == ST_DIV)
    `KAB_ASSERT_NXT(a_done_emits, i_clk, i_rst_n, (r_state == ST_DONE) && !(r_out_valid && i_out_stall), r_out_valid && (r_state == ST_IDLE))

endmodule
`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the two-state angle/bias Kalman filter.
// Depends on kab_pkg and kalman_angle_bias_filter; predicts each result in SV.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import kab_pkg::*;

    typedef struct {
        logic signed [31:0] rate;
        logic signed [31:0] meas;
        logic [15:0]        dt;
    } t_sample;

    typedef struct {
        logic signed [31:0] angle;
        logic signed [31:0] bias;
    } t_estimate;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [31:0] i_gyro_rate = '0;
    logic signed [31:0] i_measured_angle = '0;
    logic [15:0]        i_elapsed_time = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_filtered_angle;
    logic signed [31:0] o_rate_bias;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    kalman_angle_bias_filter dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [30:0]        q_angle, q_bias, r_meas;
    logic signed [31:0] est_angle, est_bias, p00, p01, p10, p11;

    t_sample   pending_samples[$];
    t_estimate expected_estimates[$];
    int        mismatches = 0;
    int        received = 0;
    bit        in_taken = 1'b0;
    bit        hold_sender = 1'b0;
    longint    cycles = 0;

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'sh7fffffff;
        if (v < -128'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // round half up: floor((v + 2^(n-1)) / 2^n)
    function automatic logic signed [127:0] rnd(input logic signed [127:0] v, input int n);
        logic signed [127:0] t;
        t = v + (128'sd1 <<< (n - 1));
        return t >>> n;
    endfunction

    function automatic logic signed [31:0] gain(input logic signed [127:0] num,
                                                input logic signed [127:0] den);
        if (den == 0) return 32'sd0;
        return clamp32((num * 128'sd16777216) / den);
    endfunction

    function automatic void reset_filter_model();
        q_angle = RST_ANGLE_NOISE;
        q_bias = RST_BIAS_NOISE;
        r_meas = RST_MEAS_NOISE;
        est_angle = 0; est_bias = 0; p00 = 0; p01 = 0; p10 = 0; p11 = 0;
    endfunction

    function automatic t_estimate update_filter(input t_sample s);
        logic signed [127:0] dt, rate, dtp11, inner, sv, y;
        logic signed [31:0]  k0, k1, a00, a01;
        t_estimate r;
        dt = {112'd0, s.dt};
        rate = clamp32(128'(s.rate) - 128'(est_bias));
        est_angle = clamp32(128'(est_angle) + rnd(rate * dt, 16));
        dtp11 = rnd(dt * 128'(p11), 16);
        inner = dtp11 - 128'(p01) - 128'(p10) + {97'd0, q_angle};
        a00 = p00; a01 = p01;
        p00 = clamp32(128'(a00) + rnd(dt * inner, 16));
        p01 = clamp32(128'(a01) - dtp11);
        p10 = clamp32(128'(p10) - dtp11);
        p11 = clamp32(128'(p11) + rnd(dt * {97'd0, q_bias}, 16));
        y = clamp32(128'(s.meas) - 128'(est_angle));
        sv = 128'(p00) + {97'd0, r_meas};
        k0 = gain(128'(p00), sv);
        k1 = gain(128'(p10), sv);
        est_angle = clamp32(128'(est_angle) + rnd(128'(k0) * y, 24));
        est_bias = clamp32(128'(est_bias) + rnd(128'(k1) * y, 24));
        a00 = p00; a01 = p01;
        p00 = clamp32(128'(a00) - rnd(128'(k0) * 128'(a00), 24));
        p01 = clamp32(128'(a01) - rnd(128'(k0) * 128'(a01), 24));
        p10 = clamp32(128'(p10) - rnd(128'(k1) * 128'(a00), 24));
        p11 = clamp32(128'(p11) - rnd(128'(k1) * 128'(a01), 24));
        r.angle = est_angle;
        r.bias = est_bias;
        return r;
    endfunction

    // driver: bursts with random gaps; a request moves on only once taken
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            in_taken = 1'b0;
            if (!hold_sender && pending_samples.size() > 0 && gap_left == 0) begin
                t_sample s;
                s = pending_samples.pop_front();
                i_in_valid <= 1'b1;
                i_gyro_rate <= s.rate;
                i_measured_angle <= s.meas;
                i_elapsed_time <= s.dt;
                expected_estimates.push_back(update_filter(s));
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 8);
                end
                burst_left--;
                if (burst_left == 0 && $urandom_range(0, 2) != 0)
                    gap_left = $urandom_range(1, 300);
            end else begin
                i_in_valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) in_taken = 1'b1;
    end

    // receiver stall pattern: alternating quiet and stalling stretches
    int stall_phase = 0;
    always @(negedge i_clk) begin
        stall_phase <= (stall_phase + 1) % 4000;
        if (stall_phase < 1500) i_out_stall <= 1'b0;
        else if (stall_phase < 2800) i_out_stall <= ($urandom_range(0, 3) == 0);
        else i_out_stall <= ($urandom_range(0, 9) < 8);
    end

    // monitor
    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            received++;
            if (expected_estimates.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %0d", received);
            end else begin
                t_estimate e;
                e = expected_estimates.pop_front();
                if (e.angle !== o_filtered_angle || e.bias !== o_rate_bias) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: exp angle %0d bias %0d, got angle %0d bias %0d",
                                 received, e.angle, e.bias, o_filtered_angle, o_rate_bias);
                end
            end
        end
        if (cycles > 4000000) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_ANGLE_NOISE: q_angle = value[30:0];
            REG_BIAS_NOISE:  q_bias = value[30:0];
            default:         r_meas = value[30:0];
        endcase
    endtask

    task automatic add_sample(input logic [31:0] r, input logic [31:0] m,
                              input logic [15:0] d);
        t_sample s;
        s.rate = r; s.meas = m; s.dt = d;
        pending_samples.push_back(s);
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || expected_estimates.size() > 0 || i_in_valid)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    // realistic motion with noisy sensor values, plus some wild items
    task automatic add_random(input int n);
        int ang;
        ang = $urandom_range(0, 180 << 16) - (90 << 16);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0: add_sample($urandom, $urandom, 16'($urandom));
                1: add_sample($urandom, $urandom, 16'($urandom_range(0, 3)));
                default: begin
                    ang = ang + $signed($urandom_range(0, 1 << 17)) - (1 << 16);
                    add_sample($signed($urandom_range(0, 200 << 16)) - (100 << 16),
                               ang + $signed($urandom_range(0, 1 << 18)) - (1 << 17),
                               16'($urandom_range(10, 2000)));
                end
            endcase
        end
    endtask

    initial begin
        reset_filter_model();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, zero divisor (zero measurement noise at start)
        write_reg(REG_MEAS_NOISE, 32'h0);
        add_sample(32'h0, 32'h0, 16'h0);
        add_sample(32'h7fffffff, 32'h80000000, 16'hffff);
        drain();
        write_reg(REG_MEAS_NOISE, 32'hffffffff);
        write_reg(REG_ANGLE_NOISE, 32'h7fffffff);
        write_reg(REG_BIAS_NOISE, 32'h7fffffff);
        add_sample(32'h80000000, 32'h7fffffff, 16'hffff);
        add_sample(32'h7fffffff, 32'h7fffffff, 16'hffff);
        add_sample(32'h80000000, 32'h80000000, 16'h0001);
        add_sample(32'hffffffff, 32'h00000001, 16'h8000);
        add_sample(32'h12345678, 32'hedcba987, 16'h5555);
        add_sample(32'h0, 32'h0, 16'h0);
        drain();
        write_reg(REG_ANGLE_NOISE, 32'h0);
        write_reg(REG_BIAS_NOISE, 32'h0);
        write_reg(REG_MEAS_NOISE, 32'h1);
        add_sample(32'h00010000, 32'h00100000, 16'h0100);
        add_sample(32'hffff0000, 32'hfff00000, 16'hffff);
        add_random(8);
        drain();
        // sender pauses while new samples queue up, then is released
        hold_sender = 1'b1;
        add_random(5);
        repeat (200) @(posedge i_clk);
        hold_sender = 1'b0;
        drain();
        write_reg(REG_ANGLE_NOISE, 32'(RST_ANGLE_NOISE));
        write_reg(REG_BIAS_NOISE, 32'(RST_BIAS_NOISE));
        write_reg(REG_MEAS_NOISE, 32'(RST_MEAS_NOISE));
        add_random(700);
        drain();
        write_reg(REG_ANGLE_NOISE, $urandom);
        write_reg(REG_BIAS_NOISE, $urandom_range(0, 1 << 20));
        write_reg(REG_MEAS_NOISE, $urandom_range(0, 1 << 26));
        add_random(600);
        drain();
        write_reg(REG_ANGLE_NOISE, $urandom_range(0, 1 << 16));
        write_reg(REG_BIAS_NOISE, $urandom);
        write_reg(REG_MEAS_NOISE, $urandom);
        add_random(580);
        drain();
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
+incdir+rtl/core
rtl/core/kab_pkg.sv
rtl/core/kab_mul.sv
rtl/core/kab_div.sv
rtl/core/kalman_angle_bias_filter.sv
test/testbench.sv
